// ===== src/mbrtu_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the transaction unit.
package mbrtu_pkg;

  typedef enum logic [1:0] {
    OpStart   = 2'd0,
    OpByte    = 2'd1,
    OpTimeout = 2'd2
  } op_e;

  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPoly     = 16'hA001;
  localparam logic [7:0]  ExcFlag     = 8'h80;
  localparam logic [8:0]  ExcLen      = 9'd5;
  localparam logic [8:0]  MaxLenReset = 9'd260;
  localparam logic [8:0]  SkipLast    = 9'd4;
  localparam logic [8:0]  HdrLast     = 9'd2;
  localparam logic [2:0]  CrcLoIdx    = 3'd6;
  localparam logic [2:0]  ReqLastIdx  = 3'd7;

  // Request values that the reply checker compares against.
  typedef struct packed {
    logic [7:0] slave;
    logic [7:0] func;
    logic [7:0] addr_hi;
    logic       accept;
  } held_t;

  // One transaction outcome, valid for the cycle in which it is decided.
  typedef struct packed {
    logic       valid;
    logic       fail;
    logic [8:0] len;
    logic       exc;
  } outcome_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/mbrtu_rx_check.sv =====
// Reply checker: header echo skip, frame length, CRC check and outcome decision.
module mbrtu_rx_check import mbrtu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] op_i,
  input  logic [7:0] rx_byte_i,
  input  held_t      held_i,
  input  logic [8:0] max_len_i,
  output outcome_t   outcome_o
);

  typedef enum logic [3:0] {
    PhIdle   = 4'b0001,
    PhHeader = 4'b0010,
    PhSkip   = 4'b0100,
    PhBody   = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [8:0]  exp_len_q, exp_len_d;
  logic [15:0] crc_q, crc_d;
  logic        echo_q, echo_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  hdr0_q, hdr0_d;
  logic [7:0]  hdr1_q, hdr1_d;

  logic [7:0]  exc_code;
  logic [8:0]  data_len;
  logic [8:0]  exp_m2;
  logic [15:0] crc_next;
  logic        is_exc;

  assign exc_code = held_i.func | ExcFlag;
  assign data_len = {1'b0, rx_byte_i} + ExcLen;
  assign exp_m2   = exp_len_q - 9'd2;
  assign crc_next = crc_byte(crc_q, rx_byte_i);
  assign is_exc   = (hdr1_q == exc_code);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    exp_len_d = exp_len_q;
    crc_d     = crc_q;
    echo_d    = echo_q;
    crc_lo_d  = crc_lo_q;
    hdr0_d    = hdr0_q;
    hdr1_d    = hdr1_q;
    outcome_o = '0;
    if (step_i) begin
      case (op_i)
        OpStart: begin
          phase_d   = PhHeader;
          cnt_d     = '0;
          exp_len_d = '0;
          crc_d     = CrcInit;
          echo_d    = 1'b0;
          crc_lo_d  = '0;
        end
        OpTimeout: begin
          if (phase_q != PhIdle) begin
            phase_d         = PhIdle;
            cnt_d           = '0;
            outcome_o.valid = 1'b1;
            outcome_o.fail  = 1'b1;
          end
        end
        OpByte: begin
          case (phase_q)
            PhSkip: begin
              if (cnt_q == SkipLast) begin
                phase_d = PhHeader;
                cnt_d   = '0;
                crc_d   = CrcInit;
              end else begin
                cnt_d = cnt_q + 9'd1;
              end
            end
            PhHeader: begin
              crc_d = crc_next;
              cnt_d = cnt_q + 9'd1;
              if (cnt_q == 9'd0) begin
                hdr0_d = rx_byte_i;
              end
              if (cnt_q == 9'd1) begin
                hdr1_d = rx_byte_i;
              end
              if (cnt_q == HdrLast) begin
                echo_d = 1'b1;
                if (!echo_q && hdr0_q == held_i.slave && hdr1_q == held_i.func &&
                    rx_byte_i == held_i.addr_hi) begin
                  // The request itself came back; skip its tail and read a new header.
                  phase_d = PhSkip;
                  cnt_d   = '0;
                end else if (hdr0_q != held_i.slave ||
                             (hdr1_q != exc_code && hdr1_q != held_i.func) ||
                             (hdr1_q == exc_code && ExcLen > max_len_i) ||
                             (hdr1_q != exc_code && data_len > max_len_i)) begin
                  phase_d         = PhIdle;
                  cnt_d           = '0;
                  outcome_o.valid = 1'b1;
                  outcome_o.fail  = 1'b1;
                end else begin
                  phase_d   = PhBody;
                  exp_len_d = (hdr1_q == exc_code) ? ExcLen : data_len;
                end
              end
            end
            PhBody: begin
              if (cnt_q < exp_m2) begin
                crc_d = crc_next;
                cnt_d = cnt_q + 9'd1;
              end else if (cnt_q == exp_m2) begin
                crc_lo_d = rx_byte_i;
                cnt_d    = cnt_q + 9'd1;
              end else begin
                phase_d         = PhIdle;
                cnt_d           = '0;
                outcome_o.valid = 1'b1;
                if (crc_lo_q != crc_q[7:0] || rx_byte_i != crc_q[15:8] ||
                    (is_exc && !held_i.accept)) begin
                  outcome_o.fail = 1'b1;
                end else begin
                  outcome_o.len = exp_len_q;
                  outcome_o.exc = is_exc;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      cnt_q     <= '0;
      exp_len_q <= '0;
      crc_q     <= CrcInit;
      echo_q    <= 1'b0;
      crc_lo_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      exp_len_q <= exp_len_d;
      crc_q     <= crc_d;
      echo_q    <= echo_d;
      crc_lo_q  <= crc_lo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr0_q <= hdr0_d;
    hdr1_q <= hdr1_d;
  end

  // The limit may be rewritten while a frame is still open, so only the fixed bounds hold.
  a_body_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhBody |-> exp_len_q >= ExcLen && exp_len_q <= MaxLenReset)
    else $error("body phase with an impossible frame length");

  a_hdr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHeader |-> cnt_q <= HdrLast)
    else $error("header counter ran past the header");

  a_skip_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhSkip |-> cnt_q <= SkipLast)
    else $error("skip counter ran past the echoed tail");

endmodule

// ===== src/modbus_rtu_master_transaction_unit.sv =====
// Top level of the Modbus RTU master read transaction unit.
// Usage: each input word carries an op. A start word latches the request and
// produces eight transmit words (slave, function, address, quantity, then the
// CRC-16/MODBUS low byte and high byte); the eighth has last set. Received
// byte words are checked against the request and the reply frame; once the
// frame is complete or rejected, or on a timeout word while a reply is
// awaited, a single outcome word (kind 1, last 1) reports success with the
// frame length, or failure. Bytes or timeouts while idle and op code 3
// produce nothing. The configuration channel writes the largest accepted
// reply length; it is always ready and takes effect from the next word.
// An input word is registered in the input register, then decided once the
// output register is free; its result words go out through that register.
// Throughput: one input word per cycle while the output side keeps up; a
// start word holds the output until all eight transmit words are taken,
// limited by the single output register.
// When the receiver stalls, one further input word waits in the input
// register. Reset empties both registers, returns the checker to idle and
// sets the length limit to 260.
module modbus_rtu_master_transaction_unit import mbrtu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  slave_address_i,
  input  logic [7:0]  function_code_i,
  input  logic [15:0] register_address_i,
  input  logic [15:0] quantity_i,
  input  logic        accept_exception_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic        status_o,
  output logic [8:0]  response_length_o,
  output logic        exception_reply_o
);

  logic [8:0]  max_len_q;

  logic        in_full_q;
  logic [1:0]  op_q;
  logic [7:0]  slave_q;
  logic [7:0]  func_q;
  logic [15:0] addr_q;
  logic [15:0] qty_q;
  logic        accept_q;
  logic [7:0]  rx_q;

  logic [7:0]  held_slave_q;
  logic [7:0]  held_func_q;
  logic [15:0] held_addr_q;
  logic [15:0] held_qty_q;
  logic        held_accept_q;

  logic        out_valid_q;
  logic        out_req_q;
  logic [2:0]  idx_q;
  logic [15:0] txcrc_q;
  logic        fail_q;
  logic [8:0]  len_q;
  logic        exc_q;

  logic        out_last;
  logic        out_free;
  logic        core_take;
  logic        in_load;
  logic        out_fire;
  logic [7:0]  req_byte;
  held_t       held;
  outcome_t    outcome;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    case (idx_q)
      3'd0:    req_byte = held_slave_q;
      3'd1:    req_byte = held_func_q;
      3'd2:    req_byte = held_addr_q[15:8];
      3'd3:    req_byte = held_addr_q[7:0];
      3'd4:    req_byte = held_qty_q[15:8];
      3'd5:    req_byte = held_qty_q[7:0];
      3'd6:    req_byte = txcrc_q[7:0];
      default: req_byte = txcrc_q[15:8];
    endcase
  end

  assign out_last   = !out_req_q || (idx_q == ReqLastIdx);
  assign out_fire   = out_valid_q && out_ready_i;
  assign out_free   = !out_valid_q || (out_ready_i && out_last);
  assign core_take  = in_full_q && out_free;
  assign in_ready_o = !in_full_q || core_take;
  assign in_load    = in_valid_i && in_ready_o;

  assign held = '{slave: held_slave_q, func: held_func_q, addr_hi: held_addr_q[15:8],
                  accept: held_accept_q};

  mbrtu_rx_check u_rx_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (core_take),
    .op_i      (op_q),
    .rx_byte_i (rx_q),
    .held_i    (held),
    .max_len_i (max_len_q),
    .outcome_o (outcome)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_load) begin
      in_full_q <= 1'b1;
    end else if (core_take) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      op_q     <= op_i;
      slave_q  <= slave_address_i;
      func_q   <= function_code_i;
      addr_q   <= register_address_i;
      qty_q    <= quantity_i;
      accept_q <= accept_exception_i;
      rx_q     <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_take && op_q == OpStart) begin
      held_slave_q  <= slave_q;
      held_func_q   <= func_q;
      held_addr_q   <= addr_q;
      held_qty_q    <= qty_q;
      held_accept_q <= accept_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_req_q   <= 1'b0;
      idx_q       <= '0;
    end else if (core_take && op_q == OpStart) begin
      out_valid_q <= 1'b1;
      out_req_q   <= 1'b1;
      idx_q       <= '0;
    end else if (core_take && outcome.valid) begin
      out_valid_q <= 1'b1;
      out_req_q   <= 1'b0;
    end else if (out_fire) begin
      if (out_last) begin
        out_valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  // The request CRC is built one byte per transmitted word.
  always_ff @(posedge clk_i) begin
    if (core_take && op_q == OpStart) begin
      txcrc_q <= CrcInit;
    end else if (out_fire && out_req_q && idx_q < CrcLoIdx) begin
      txcrc_q <= crc_byte(txcrc_q, req_byte);
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_take && outcome.valid) begin
      fail_q <= outcome.fail;
      len_q  <= outcome.len;
      exc_q  <= outcome.exc;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = !out_req_q;
  assign tx_byte_o         = out_req_q ? req_byte : 8'h00;
  assign last_o            = out_last;
  assign status_o          = out_req_q ? 1'b0 : fail_q;
  assign response_length_o = out_req_q ? 9'd0 : len_q;
  assign exception_reply_o = out_req_q ? 1'b0 : exc_q;

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_full_q && !out_free |=> in_full_q && $stable(op_q) && $stable(rx_q))
    else $error("buffered input word lost while the output was busy");

  a_req_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_req_q && idx_q != ReqLastIdx
    |=> out_valid_q && out_req_q && idx_q == $past(idx_q) + 3'd1)
    else $error("request byte sequence broken");

  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o && !status_o |-> response_length_o >= ExcLen)
    else $error("successful outcome with a short frame length");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o && status_o |-> response_length_o == 9'd0 && !exception_reply_o)
    else $error("failure outcome carries reply details");

endmodule

// ===== tb/mbrtu_tb_pkg.sv =====
// Word types, CRC helper and the checking scoreboard for the transaction unit testbench.
package mbrtu_tb_pkg;
  import mbrtu_pkg::*;

  localparam logic [1:0] OpReserved = 2'd3;
  localparam int SkipBytes = 5;

  typedef enum logic [1:0] {
    PhIdle,
    PhHeader,
    PhSkip,
    PhBody
  } phase_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] qty;
    logic        accept;
    logic [7:0]  rx;
  } word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx;
    logic       last;
    logic       status;
    logic [8:0] len;
    logic       exc;
  } result_t;

  // Bit-serial form of the reflected CRC-16 update, one data bit per step.
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c = c >> 1;
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  class txn_scoreboard;
    result_t     pending_results[$];
    int unsigned errors;
    int unsigned live_words;
    logic [8:0]  max_len;
    phase_e      phase;
    int          cnt;
    logic [7:0]  hdr[3];
    int          frame_len;
    logic [15:0] crc;
    bit          echo_done;
    logic [7:0]  crc_lo;
    logic [7:0]  h_slave;
    logic [7:0]  h_func;
    logic [7:0]  h_addr_hi;
    bit          h_accept;

    function new();
      errors = 0;
      live_words = 0;
      max_len = MaxLenReset;
      phase = PhIdle;
      cnt = 0;
      frame_len = 0;
      crc = CrcInit;
      echo_done = 1'b0;
      crc_lo = '0;
      h_slave = '0;
      h_func = '0;
      h_addr_hi = '0;
      h_accept = 1'b0;
    endfunction

    function void set_limit(logic [8:0] v);
      max_len = v;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function bit awaiting_reply();
      return phase != PhIdle;
    endfunction

    function void push_tx(logic [7:0] b, bit lst);
      result_t r;
      r = '0;
      r.tx = b;
      r.last = lst;
      pending_results.push_back(r);
    endfunction

    function void conclude(bit ok, int len, bit exc);
      result_t r;
      r = '0;
      r.kind = 1'b1;
      r.last = 1'b1;
      r.status = !ok;
      if (ok) begin
        r.len = len[8:0];
        r.exc = exc;
      end
      pending_results.push_back(r);
      phase = PhIdle;
      cnt = 0;
    endfunction

    // Called for every accepted input word; queues the result words it causes.
    function void note_word(word_t w);
      logic [7:0]  req[8];
      logic [15:0] c;
      logic [7:0]  exc_code;
      bit          is_exc;
      if (w.op == OpStart) begin
        req = '{w.slave, w.func, w.addr[15:8], w.addr[7:0], w.qty[15:8], w.qty[7:0],
                8'h00, 8'h00};
        c = CrcInit;
        for (int i = 0; i < 6; i++) c = crc16_update(c, req[i]);
        req[6] = c[7:0];
        req[7] = c[15:8];
        for (int i = 0; i < 8; i++) push_tx(req[i], i == 7);
        h_slave = w.slave;
        h_func = w.func;
        h_addr_hi = w.addr[15:8];
        h_accept = w.accept;
        phase = PhHeader;
        cnt = 0;
        frame_len = 0;
        crc = CrcInit;
        echo_done = 1'b0;
        crc_lo = '0;
        live_words++;
        return;
      end
      if (phase == PhIdle || w.op == OpReserved) return;
      live_words++;
      if (w.op == OpTimeout) begin
        conclude(1'b0, 0, 1'b0);
        return;
      end
      exc_code = h_func | ExcFlag;
      case (phase)
        PhSkip: begin
          cnt++;
          if (cnt >= SkipBytes) begin
            phase = PhHeader;
            cnt = 0;
            crc = CrcInit;
          end
        end
        PhHeader: begin
          hdr[cnt] = w.rx;
          crc = crc16_update(crc, w.rx);
          cnt++;
          if (cnt == 3) begin
            // Only the first header may be taken as an echo of the request.
            if (!echo_done && hdr[0] == h_slave && hdr[1] == h_func &&
                hdr[2] == h_addr_hi) begin
              echo_done = 1'b1;
              phase = PhSkip;
              cnt = 0;
            end else begin
              echo_done = 1'b1;
              if (hdr[0] != h_slave) begin
                conclude(1'b0, 0, 1'b0);
              end else if (hdr[1] == exc_code || hdr[1] == h_func) begin
                frame_len = (hdr[1] == exc_code) ? int'(ExcLen) : int'(hdr[2]) + 5;
                if (frame_len > int'(max_len)) conclude(1'b0, 0, 1'b0);
                else phase = PhBody;
              end else begin
                conclude(1'b0, 0, 1'b0);
              end
            end
          end
        end
        default: begin
          if (cnt < frame_len - 2) begin
            crc = crc16_update(crc, w.rx);
            cnt++;
          end else if (cnt == frame_len - 2) begin
            crc_lo = w.rx;
            cnt++;
          end else begin
            is_exc = (hdr[1] == exc_code);
            if (crc_lo != crc[7:0] || w.rx != crc[15:8] || (is_exc && !h_accept))
              conclude(1'b0, 0, 1'b0);
            else
              conclude(1'b1, frame_len, is_exc);
          end
        end
      endcase
    endfunction

    function void report(bit stray, result_t want, result_t got);
      errors++;
      if (errors > 10) return;
      if (stray)
        $display("result word with nothing expected: kind %0d tx %h last %0d status %0d len %0d exc %0d",
                 got.kind, got.tx, got.last, got.status, got.len, got.exc);
      else
        $display("result mismatch: expected kind %0d tx %h last %0d status %0d len %0d exc %0d",
                 want.kind, want.tx, want.last, want.status, want.len, want.exc,
                 ", got kind %0d tx %h last %0d status %0d len %0d exc %0d",
                 got.kind, got.tx, got.last, got.status, got.len, got.exc);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report(1'b1, '0, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.tx !== want.tx || got.last !== want.last ||
          got.status !== want.status || got.len !== want.len || got.exc !== want.exc)
        report(1'b0, want, got);
    endfunction
  endclass

endpackage

// ===== tb/modbus_rtu_master_transaction_unit_tb.sv =====
// Self-checking testbench for the Modbus RTU master transaction unit.
module modbus_rtu_master_transaction_unit_tb;
  import mbrtu_pkg::*;
  import mbrtu_tb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [8:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [7:0]  slave_address_i = '0;
  logic [7:0]  function_code_i = '0;
  logic [15:0] register_address_i = '0;
  logic [15:0] quantity_i = '0;
  logic        accept_exception_i = 1'b0;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic        status_o;
  logic [8:0]  response_length_o;
  logic        exception_reply_o;

  txn_scoreboard sb;
  bit            quiet = 1'b0;

  modbus_rtu_master_transaction_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .slave_address_i    (slave_address_i),
    .function_code_i    (function_code_i),
    .register_address_i (register_address_i),
    .quantity_i         (quantity_i),
    .accept_exception_i (accept_exception_i),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_o             (kind_o),
    .tx_byte_o          (tx_byte_o),
    .last_o             (last_o),
    .status_o           (status_o),
    .response_length_o  (response_length_o),
    .exception_reply_o  (exception_reply_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    result_t seen;
    seen = {kind_o, tx_byte_o, last_o, status_o, response_length_o, exception_reply_o};
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(seen);
    out_ready_i <= quiet || ($urandom_range(99) >= 7);
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic word_t rand_word(logic [1:0] op);
    word_t       w;
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    w = r[$bits(word_t)-1:0];
    w.op = op;
    return w;
  endfunction

  // Appends the CRC of the bytes from position first onwards, low byte first.
  function automatic void seal_frame(ref logic [7:0] f[$], input int first);
    logic [15:0] c;
    c = CrcInit;
    for (int i = first; i < f.size(); i++) c = crc16_update(c, f[i]);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
  endfunction

  // Valid stays high across back-to-back words; it is only lowered for a gap.
  task automatic send_word(word_t w);
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= w.op;
    slave_address_i <= w.slave;
    function_code_i <= w.func;
    register_address_i <= w.addr;
    quantity_i <= w.qty;
    accept_exception_i <= w.accept;
    rx_byte_i <= w.rx;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
  endtask

  task automatic send_byte(logic [7:0] b);
    word_t w;
    w = rand_word(OpByte);
    w.rx = b;
    send_word(w);
  endtask

  // Feeds reply bytes; a rough frame may carry stray words or end in a timeout.
  task automatic send_frame(logic [7:0] f[$], bit rough);
    foreach (f[i]) begin
      if (i > 0 && !sb.awaiting_reply()) break;
      if (rough && $urandom_range(99) < 2) begin
        send_word(rand_word(OpTimeout));
        return;
      end
      if (rough && $urandom_range(99) < 2) send_word(rand_word(OpReserved));
      send_byte(f[i]);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [8:0] v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_limit(v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic directed_run();
    word_t        w;
    logic [7:0] f[$];
    // Words while idle must be ignored.
    send_word(rand_word(OpReserved));
    send_word(rand_word(OpByte));
    send_word(rand_word(OpTimeout));
    // All-zero request, then a timeout.
    w = '0;
    w.op = OpStart;
    send_word(w);
    send_word(rand_word(OpTimeout));
    // All-ones request: the echo is skipped and an accepted exception follows.
    w = '1;
    w.op = OpStart;
    send_word(w);
    f = {8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'hFF, 8'hFF, 8'h01};
    seal_frame(f, 8);
    send_frame(f, 1'b0);
    // A second request drops the first; the exception that follows is refused.
    w = rand_word(OpStart);
    w.slave = 8'h11;
    w.func = 8'h03;
    w.addr = 16'h006B;
    w.qty = 16'h0003;
    w.accept = 1'b0;
    send_word(w);
    send_byte(8'h11);
    send_word(w);
    f = {8'h11, 8'h83, 8'h02};
    seal_frame(f, 0);
    send_frame(f, 1'b0);
    send_byte(8'h00);
  endtask

  task automatic random_transaction();
    word_t        w;
    logic [7:0] f[$];
    logic [7:0]   fc;
    logic [7:0]   bc;
    int           pick;
    int           echoes;
    int           span;
    int           lim;
    int           first;
    if ($urandom_range(99) < 4) send_word(rand_word(2'($urandom_range(3))));
    w = rand_word(OpStart);
    case ($urandom_range(7))
      0: w.func = 8'h03;
      1: w.func = 8'h04;
      2: w.func = 8'h01;
      3: w.func = 8'h02;
      4: w.func = ExcFlag | 8'($urandom_range(7));
      5: w.func = 8'hFF;
      6: w.func = 8'h00;
      default: ;
    endcase
    send_word(w);
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_word(rand_word(OpTimeout));
      return;
    end
    if (pick < 12) return;
    echoes = (pick < 32) ? 1 : (pick < 34) ? 2 : 0;
    repeat (echoes) begin
      f.push_back(w.slave);
      f.push_back(w.func);
      f.push_back(w.addr[15:8]);
      repeat (SkipBytes) f.push_back(8'($urandom));
    end
    first = f.size();
    pick = $urandom_range(99);
    fc = w.func;
    if (pick < 25) fc = w.func | ExcFlag;
    else if (pick < 32) fc = 8'($urandom);
    f.push_back(($urandom_range(99) < 6) ? 8'($urandom) : w.slave);
    f.push_back(fc);
    // Byte counts mostly small, a few anywhere, some at the length limit or one byte past it.
    lim = int'(sb.max_len);
    pick = $urandom_range(99);
    if (pick < 3) begin
      bc = 8'($urandom);
    end else if (pick < 9 && lim >= 5 && lim <= 260) begin
      span = lim - 5 + int'($urandom_range(1));
      bc = (span > 255) ? 8'hFF : 8'(span);
    end else begin
      bc = 8'($urandom_range(10));
    end
    f.push_back(bc);
    if (fc != (w.func | ExcFlag)) repeat (bc) f.push_back(8'($urandom));
    seal_frame(f, first);
    if ($urandom_range(99) < 10) begin
      pick = $urandom_range(f.size() - 1, first);
      f[pick] = f[pick] ^ (8'h01 << $urandom_range(7));
    end
    send_frame(f, 1'b1);
  endtask

  task automatic random_phase(int words);
    int unsigned target;
    target = sb.live_words + words;
    while (sb.live_words < target) random_transaction();
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_run();
    random_phase(48);
    write_limit(9'd5);
    random_phase(48);
    write_limit(9'd511);
    quiet = 1'b1;
    random_phase(48);
    quiet = 1'b0;
    write_limit(9'd0);
    random_phase(40);
    write_limit(9'd4);
    random_phase(40);
    write_limit(9'($urandom_range(259, 6)));
    random_phase(52);
    write_limit(9'd12);
    random_phase(52);
    write_limit(9'd260);
    random_phase(52);
    wait_idle();
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== modbus_rtu_master_transaction_unit.f =====
src/mbrtu_pkg.sv
src/mbrtu_rx_check.sv
src/modbus_rtu_master_transaction_unit.sv
tb/mbrtu_tb_pkg.sv
tb/modbus_rtu_master_transaction_unit_tb.sv
